/* src/polar_to_rectangular_macros.svh */
// Assertion macros shared by the checker of the polar to rectangular block.
`ifndef POLAR_TO_RECTANGULAR_MACROS_SVH
`define POLAR_TO_RECTANGULAR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cpr_pkg.sv */
package cpr_pkg;

    localparam int STAGES    = 16;
    localparam int TABLE_LEN = 24;
    localparam int NUM_ROT   = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
    localparam int IDXW      = $clog2(TABLE_LEN);

    localparam int MAG_W  = 16;
    localparam int ANG_W  = 16;
    localparam int OUT_W  = 17;
    localparam int GAIN_W = 32;
    localparam int FRAC   = 24;
    localparam int XW     = 43;
    localparam int ZW     = 34;
    localparam int RW     = XW - FRAC;

    localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'h9B74EDA8;
    localparam int                OUT_MAX  = 65535;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cpr_data_t;

    function automatic logic [31:0] atan_turn(input logic [IDXW-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

/* src/cpr_stage.sv */
module cpr_stage
    import cpr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IDXW-1:0] stage_idx,
    input  logic            in_valid,
    output logic            in_ready,
    input  cpr_data_t       in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cpr_data_t       out_data
);

    logic                 valid_reg;
    cpr_data_t            data_reg;
    cpr_data_t            data_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] dz;

    assign dx = in_data.y >>> stage_idx;
    assign dy = in_data.x >>> stage_idx;
    assign dz = signed'({{(ZW - 32){1'b0}}, atan_turn(stage_idx)});

    // A residual angle of zero rotates in the positive direction.
    always_comb
    begin
        if (!in_data.z[ZW-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - dz;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + dz;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* src/polar_to_rectangular.sv */
// Channel  | Handshake            | Payload
// request  | req_valid, req_ready | magnitude [15:0] unsigned, angle [15:0] signed
// result   | res_valid, res_ready | real_part [16:0] signed, imag_part [16:0] signed
//
// One request enters per cycle unless results stall; each gives one result.
// The stages are a gain multiply with quadrant fold, one register per rotation,
// and a round and saturate register.
// Reset clears only the valid bits; data registers are not reset.
// Each stage holds its item while the next one is full and stalled, so a bubble
// anywhere is filled and nothing is dropped or repeated.
module polar_to_rectangular
    import cpr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic        [MAG_W-1:0] magnitude,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic signed [OUT_W-1:0] real_part,
    output logic signed [OUT_W-1:0] imag_part
);

    logic [MAG_W+GAIN_W-1:0] prod;
    logic signed [XW-1:0]    x_scaled;
    logic                    fold;
    logic [ANG_W-1:0]        ang_folded;
    cpr_data_t               front_next;
    cpr_data_t               front_reg;
    logic                    front_valid_reg;

    cpr_data_t               chain_data  [0:NUM_ROT];
    logic                    chain_valid [0:NUM_ROT];
    logic                    chain_ready [0:NUM_ROT];

    logic signed [XW-1:0]    x_round;
    logic signed [XW-1:0]    y_round;
    logic signed [OUT_W-1:0] real_next;
    logic signed [OUT_W-1:0] imag_next;
    logic signed [OUT_W-1:0] real_reg;
    logic signed [OUT_W-1:0] imag_reg;
    logic                    res_valid_reg;
    logic                    fin_ready;

    function automatic logic signed [OUT_W-1:0] saturate(input logic signed [RW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > RW'(OUT_MAX))
        begin
            r = OUT_W'(OUT_MAX);
        end
        else if (v < -RW'(OUT_MAX))
        begin
            r = -OUT_W'(OUT_MAX);
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // Angles beyond a quarter turn are folded by half a turn with x negated.
    assign prod       = (MAG_W + GAIN_W)'(magnitude) * (MAG_W + GAIN_W)'(GAIN_Q32);
    assign x_scaled   = signed'(XW'(prod[MAG_W+GAIN_W-1:GAIN_W-FRAC]));
    assign fold       = angle[ANG_W-1] ^ angle[ANG_W-2];
    assign ang_folded = {angle[ANG_W-1] ^ fold, angle[ANG_W-2:0]};

    always_comb
    begin
        front_next.x = fold ? -x_scaled : x_scaled;
        front_next.y = '0;
        front_next.z = ZW'(signed'({ang_folded, {(32 - ANG_W){1'b0}}}));
    end

    assign req_ready = !front_valid_reg || chain_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            front_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            front_reg <= front_next;
        end
    end

    assign chain_data[0]  = front_reg;
    assign chain_valid[0] = front_valid_reg;

    for (genvar k = 0; k < NUM_ROT; k++)
    begin : g_rot
        cpr_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDXW'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    assign x_round   = chain_data[NUM_ROT].x + XW'(1 << (FRAC - 1));
    assign y_round   = chain_data[NUM_ROT].y + XW'(1 << (FRAC - 1));
    assign real_next = saturate(x_round[XW-1:FRAC]);
    assign imag_next = saturate(y_round[XW-1:FRAC]);

    assign fin_ready            = !res_valid_reg || res_ready;
    assign chain_ready[NUM_ROT] = fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            res_valid_reg <= chain_valid[NUM_ROT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[NUM_ROT] && fin_ready)
        begin
            real_reg <= real_next;
            imag_reg <= imag_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign real_part = real_reg;
    assign imag_part = imag_reg;

endmodule

/* src/polar_to_rectangular_checker.sv */
`include "polar_to_rectangular_macros.svh"

module polar_to_rectangular_checker
    import cpr_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic signed [OUT_W-1:0] real_part,
    input logic signed [OUT_W-1:0] imag_part
);

    localparam int DEPTH = NUM_ROT + 2;
    localparam int CW    = $clog2(DEPTH + 2);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          req_acc;
    logic          res_acc;

    assign req_acc = req_valid && req_ready;
    assign res_acc = res_valid && res_ready;

    // Requests in flight: accepted but whose result has not been taken yet.
    always_comb
    begin
        case ({req_acc, res_acc})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `CPR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(real_part) && $stable(imag_part), "result changed while stalled")
    `CPR_ASSERT_NOW(a_res_range, res_valid, real_part != 17'h10000 && imag_part != 17'h10000, "result outside saturation range")
    `CPR_ASSERT_NOW(a_res_has_req, res_valid, cnt_reg != '0, "result without an outstanding request")
    `CPR_ASSERT_NOW(a_depth, 1'b1, cnt_reg <= CW'(DEPTH), "more requests in flight than pipeline stages")

endmodule

bind polar_to_rectangular polar_to_rectangular_checker u_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import cpr_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } rect_t;

    typedef struct packed {
        logic [MAG_W-1:0]        mag;
        logic [ANG_W-1:0]        ang;
        logic                    known;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } polar_row_t;

    localparam int NUM_DIRECTED = 22;
    localparam int NUM_RANDOM   = 450;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [31:0] arctan_step [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // A zero magnitude gives zero on both axes whatever the angle.
    localparam polar_row_t directed_rows [NUM_DIRECTED] = '{
        '{16'd0,     16'h0000, 1'b1, 17'sd0, 17'sd0},
        '{16'd0,     16'h8000, 1'b1, 17'sd0, 17'sd0},
        '{16'd0,     16'h5A5A, 1'b1, 17'sd0, 17'sd0},
        '{16'd65535, 16'h0000, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h4000, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h8000, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'hC000, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h7FFF, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h3FFF, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h4001, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'hBFFF, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'hC001, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h2000, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'hE000, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'h0001, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'hFFFF, 1'b0, 17'sd0, 17'sd0},
        '{16'd1,     16'h0000, 1'b0, 17'sd0, 17'sd0},
        '{16'd1,     16'h4000, 1'b0, 17'sd0, 17'sd0},
        '{16'd1,     16'hA000, 1'b0, 17'sd0, 17'sd0},
        '{16'd32768, 16'h5555, 1'b0, 17'sd0, 17'sd0},
        '{16'd32767, 16'hAAAA, 1'b0, 17'sd0, 17'sd0},
        '{16'd1234,  16'h1000, 1'b0, 17'sd0, 17'sd0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_ready;
    logic        [MAG_W-1:0] magnitude;
    logic signed [ANG_W-1:0] angle;
    logic                    res_valid;
    logic                    res_ready;
    logic signed [OUT_W-1:0] real_part;
    logic signed [OUT_W-1:0] imag_part;

    rect_t pending_rect [$];
    int    mismatch_count = 0;
    bit    steady = 1'b0;

    polar_to_rectangular dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .magnitude (magnitude),
        .angle     (angle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .real_part (real_part),
        .imag_part (imag_part)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [OUT_W-1:0] round_clamp(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd8388608) >>> FRAC;
        if (r > 64'(OUT_MAX))
        begin
            r = 64'(OUT_MAX);
        end
        if (r < -64'(OUT_MAX))
        begin
            r = -64'(OUT_MAX);
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic rect_t polar_rotate(input logic [MAG_W-1:0] mag,
                                           input logic [ANG_W-1:0] ang);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] z;
        logic        [31:0] zu;
        rect_t              r;
        x  = signed'(({48'd0, mag} * {32'd0, GAIN_Q32}) >> (32 - FRAC));
        y  = '0;
        zu = {ang, 16'd0};
        // Angles past a quarter turn are folded by half a turn with x negated.
        if (zu[31] != zu[30])
        begin
            x  = -x;
            zu = zu + 32'h8000_0000;
        end
        z = {{32{zu[31]}}, zu};
        for (int i = 0; i < STAGES && i < TABLE_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - $signed({32'd0, arctan_step[i]});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + $signed({32'd0, arctan_step[i]});
            end
        end
        r.re = round_clamp(x);
        r.im = round_clamp(y);
        return r;
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 32);
    endfunction

    task automatic send_request(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang,
                                input bit known, input rect_t typed);
        req_valid <= 1'b1;
        magnitude <= mag;
        angle     <= ang;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        pending_rect.push_back(known ? typed : polar_rotate(mag, ang));
    endtask

    task automatic pause_requests();
        if (take_break())
        begin
            req_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (take_break());
        end
    endtask

    initial
    begin
        logic [MAG_W-1:0] mag;
        logic [ANG_W-1:0] ang;
        rect_t            typed;
        int               mode;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        magnitude <= '0;
        angle     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            pause_requests();
            typed.re = directed_rows[k].re;
            typed.im = directed_rows[k].im;
            send_request(directed_rows[k].mag, directed_rows[k].ang,
                         directed_rows[k].known, typed);
        end

        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            steady = (k >= 180 && k < 280);
            mode = $urandom_range(0, 9);
            mag  = MAG_W'($urandom);
            ang  = ANG_W'($urandom);
            if (mode >= 6 && mode < 8)
            begin
                mag = MAG_W'($urandom_range(0, 15));
            end
            else if (mode >= 8)
            begin
                // Angles close to a quadrant boundary.
                ang = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 6)) - 16'd3;
            end
            pause_requests();
            send_request(mag, ang, 1'b0, typed);
        end
        req_valid <= 1'b0;
        steady = 1'b0;

        while (pending_rect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        rect_t want;
        res_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
            begin
                if (pending_rect.size() == 0)
                begin
                    $error("result with no request waiting: real_part %0d imag_part %0d",
                           real_part, imag_part);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rect.pop_front();
                    if (real_part !== want.re)
                    begin
                        $error("real_part expected %0d actual %0d", want.re, real_part);
                        mismatch_count++;
                    end
                    if (imag_part !== want.im)
                    begin
                        $error("imag_part expected %0d actual %0d", want.im, imag_part);
                        mismatch_count++;
                    end
                end
            end
            res_ready <= !take_break();
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
